// ===== design/isoc_pkg.sv =====
// Package for the IMU stillness and orientation classifier.
// Holds the item types, the register set, register indexes and orientation codes.
// No dependencies.
`default_nettype none

package isoc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RATE_STILL_LIMIT     = 3'd0,
    CFG_ACCEL_NORM_LIMIT     = 3'd1,
    CFG_UPRIGHT_TILT_LIMIT   = 3'd2,
    CFG_TILT_BAND_LOW        = 3'd3,
    CFG_TILT_BAND_HIGH       = 3'd4,
    CFG_SIDE_ACCEL_LIMIT     = 3'd5,
    CFG_VERTICAL_ACCEL_LIMIT = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ORIENT_UNKNOWN     = 2'd0,
    ORIENT_UPRIGHT     = 2'd1,
    ORIENT_NOT_UPRIGHT = 2'd2
  } orient_e;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic               read_error;
  } in_t;

  typedef struct packed {
    logic        sample_valid;
    logic        is_still;
    orient_e     orientation;
    logic [16:0] rate_sum;
    logic [20:0] full_norm;
    logic [20:0] tilt_norm;
  } out_t;

  typedef struct packed {
    logic [16:0]        rate_still_limit;
    logic [14:0]        accel_norm_limit;
    logic [14:0]        upright_tilt_limit;
    logic [14:0]        tilt_band_low;
    logic [14:0]        tilt_band_high;
    logic [14:0]        side_accel_limit;
    logic signed [15:0] vertical_accel_limit;
  } cfg_t;

  typedef struct packed {
    logic               read_error;
    logic [16:0]        rate_sum;
    logic [20:0]        tilt_norm;
    logic [20:0]        full_norm;
    logic [16:0]        accel_x_mag;
    logic signed [15:0] accel_z;
  } metrics_t;

  localparam cfg_t CfgReset = '{
    rate_still_limit:     17'd200,
    accel_norm_limit:     15'd3584,
    upright_tilt_limit:   15'd410,
    tilt_band_low:        15'd820,
    tilt_band_high:       15'd2458,
    side_accel_limit:     15'd1229,
    vertical_accel_limit: 16'sd2028
  };

endpackage

`default_nettype wire

// ===== design/isoc_stream_if.sv =====
// Valid/ready channel interface used for the sample and result channels.
// The payload type is given by the instantiating level; no package dependency.
`default_nettype none

interface isoc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/isoc_datapath.sv =====
// Metric datapath: absolute rate sum, scaled squares and the two acceleration norms.
// Depends on isoc_pkg.
`default_nettype none

module isoc_datapath (
  input  isoc_pkg::in_t      sample_i,
  output isoc_pkg::metrics_t metrics_o
);

  function automatic logic [16:0] abs17(input logic signed [15:0] v);
    logic [16:0] ext;
    ext = {v[15], v};
    return v[15] ? (17'd0 - ext) : ext;
  endfunction

  logic [16:0] mag_ax, mag_ay, mag_az;
  logic [33:0] sq_ax, sq_ay, sq_az;
  logic [19:0] sc_ax, sc_ay, sc_az;
  logic [20:0] tilt;

  always_comb begin
    mag_ax = abs17(sample_i.accel_x);
    mag_ay = abs17(sample_i.accel_y);
    mag_az = abs17(sample_i.accel_z);
    sq_ax  = 34'(mag_ax) * 34'(mag_ax);
    sq_ay  = 34'(mag_ay) * 34'(mag_ay);
    sq_az  = 34'(mag_az) * 34'(mag_az);
    sc_ax  = sq_ax[30:11];
    sc_ay  = sq_ay[30:11];
    sc_az  = sq_az[30:11];
    tilt   = 21'(sc_ax) + 21'(sc_ay);

    metrics_o.read_error  = sample_i.read_error;
    metrics_o.rate_sum    = abs17(sample_i.rate_x) + abs17(sample_i.rate_y)
                          + abs17(sample_i.rate_z);
    metrics_o.tilt_norm   = tilt;
    metrics_o.full_norm   = tilt + 21'(sc_az);
    metrics_o.accel_x_mag = mag_ax;
    metrics_o.accel_z     = sample_i.accel_z;
  end

endmodule

`default_nettype wire

// ===== design/isoc_classify.sv =====
// Stillness and orientation decision from the metrics, the register set and the
// stored stationary flag. Depends on isoc_pkg.
`default_nettype none

module isoc_classify (
  input  isoc_pkg::metrics_t metrics_i,
  input  isoc_pkg::cfg_t     cfg_i,
  input  logic               still_i,
  output logic               still_o,
  output isoc_pkg::out_t     result_o
);

  logic              maybe_still;
  logic              upright;
  logic              in_band;
  isoc_pkg::orient_e orient;
  logic              still;

  always_comb begin
    maybe_still = (metrics_i.rate_sum < cfg_i.rate_still_limit)
               && (metrics_i.full_norm < 21'(cfg_i.accel_norm_limit));
    upright     = (metrics_i.tilt_norm < 21'(cfg_i.upright_tilt_limit))
               && (metrics_i.accel_z > cfg_i.vertical_accel_limit);
    in_band     = (21'(cfg_i.tilt_band_low) < metrics_i.tilt_norm)
               && (metrics_i.tilt_norm < 21'(cfg_i.tilt_band_high));

    orient = isoc_pkg::ORIENT_UNKNOWN;
    still  = still_i;
    if (metrics_i.read_error || !maybe_still) begin
      still = 1'b0;
    end else if (upright) begin
      orient = isoc_pkg::ORIENT_UPRIGHT;
      still  = 1'b1;
    end else if (in_band) begin
      if (metrics_i.accel_x_mag > 17'(cfg_i.side_accel_limit)) begin
        orient = isoc_pkg::ORIENT_NOT_UPRIGHT;
        still  = 1'b1;
      end
    end else begin
      still = 1'b0;
    end

    still_o = still;
    if (metrics_i.read_error) begin
      result_o = '0;
      result_o.orientation = isoc_pkg::ORIENT_UNKNOWN;
    end else begin
      result_o.sample_valid = 1'b1;
      result_o.is_still     = still;
      result_o.orientation  = orient;
      result_o.rate_sum     = metrics_i.rate_sum;
      result_o.full_norm    = metrics_i.full_norm;
      result_o.tilt_norm    = metrics_i.tilt_norm;
    end
  end

endmodule

`default_nettype wire

// ===== design/imu_stillness_orientation_classifier.sv =====
// IMU stillness and orientation classifier, top level.
// Depends on isoc_pkg, isoc_stream_if, isoc_datapath and isoc_classify.
//
// Each item on sample_i carries one accelerometer and gyro sample plus a read
// error flag; each produces exactly one item on result_o, in order. Both
// channels use valid/ready and an item moves when both are high.
// The limits are to be written by the user through cfg_we_i, cfg_idx_i and
// cfg_data_i only while the block is idle; the block itself does not enforce
// this. An index beyond the last register is ignored. An accepted item is held
// in an input register; the norms and the decision are then computed in one
// pass into the result register, which presents the result on result_o.
// One item is accepted in every cycle while the receiver takes results.
// The stationary flag is updated as each item enters the result register.
// When the receiver stalls, the result register holds and the input register
// takes one more item if it is empty; ready then drops.
// Reset empties both registers, clears the stationary flag and loads the
// default limits.
`default_nettype none

module imu_stillness_orientation_classifier (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  isoc_stream_if.sink                       sample_i,
  isoc_stream_if.source                     result_o,
  input  logic                              cfg_we_i,
  input  logic [isoc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [isoc_pkg::CfgDataW-1:0]     cfg_data_i
);

  isoc_pkg::cfg_t     cfg_q;
  isoc_pkg::in_t      s1_q;
  logic               s1_valid_q;
  isoc_pkg::out_t     out_q;
  logic               out_valid_q;
  logic               still_q;

  isoc_pkg::metrics_t metrics;
  isoc_pkg::out_t     out_d;
  logic               still_d;
  logic               out_load;
  logic               s1_load;

  assign out_load = s1_valid_q && (!out_valid_q || result_o.ready);
  assign sample_i.ready = !s1_valid_q || out_load;
  assign s1_load = sample_i.valid && sample_i.ready;

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

  isoc_datapath u_datapath (
    .sample_i  (s1_q),
    .metrics_o (metrics)
  );

  isoc_classify u_classify (
    .metrics_i (metrics),
    .cfg_i     (cfg_q),
    .still_i   (still_q),
    .still_o   (still_d),
    .result_o  (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= isoc_pkg::CfgReset;
    end else if (cfg_we_i) begin
      unique case (isoc_pkg::cfg_idx_e'(cfg_idx_i))
        isoc_pkg::CFG_RATE_STILL_LIMIT:     cfg_q.rate_still_limit   <= cfg_data_i;
        isoc_pkg::CFG_ACCEL_NORM_LIMIT:     cfg_q.accel_norm_limit   <= cfg_data_i[14:0];
        isoc_pkg::CFG_UPRIGHT_TILT_LIMIT:   cfg_q.upright_tilt_limit <= cfg_data_i[14:0];
        isoc_pkg::CFG_TILT_BAND_LOW:        cfg_q.tilt_band_low      <= cfg_data_i[14:0];
        isoc_pkg::CFG_TILT_BAND_HIGH:       cfg_q.tilt_band_high     <= cfg_data_i[14:0];
        isoc_pkg::CFG_SIDE_ACCEL_LIMIT:     cfg_q.side_accel_limit   <= cfg_data_i[14:0];
        isoc_pkg::CFG_VERTICAL_ACCEL_LIMIT: begin
          cfg_q.vertical_accel_limit <= $signed(cfg_data_i[15:0]);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      still_q     <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= 1'b1;
      end else if (out_load) begin
        s1_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        still_q     <= still_d;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_q <= sample_i.payload;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  a_error_result_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.sample_valid) |->
      (!out_q.is_still && out_q.orientation == isoc_pkg::ORIENT_UNKNOWN
       && out_q.rate_sum == '0 && out_q.full_norm == '0 && out_q.tilt_norm == '0))
    else $error("read error result not cleared");

  a_known_orient_is_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.orientation != isoc_pkg::ORIENT_UNKNOWN) |-> out_q.is_still)
    else $error("orientation reported while not still");

  a_flag_matches_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.is_still == still_q))
    else $error("stationary flag differs from the pending result");

  a_tilt_below_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.tilt_norm <= out_q.full_norm))
    else $error("horizontal norm exceeds total norm");

endmodule

`default_nettype wire

// ===== tb/tb_imu_stillness_orientation_classifier.sv =====
// Self-checking testbench for the IMU stillness and orientation classifier.
// Drives sample items and limit writes, predicts every result item and checks it in order.
// Depends on isoc_pkg, isoc_stream_if and imu_stillness_orientation_classifier.
`timescale 1ns / 1ps

module tb_imu_stillness_orientation_classifier;
  import isoc_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int DrainLimit = 5000;
  localparam int HoldOffCycles = 64;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 3'd7;

  typedef struct packed {
    in_t  sample;
    logic typed;
    out_t result;
  } vector_t;

  localparam out_t NoResult = '0;
  localparam out_t ErrorResult = '0;

  localparam int NumDirected = 24;
  localparam vector_t DirectedRows [NumDirected] = '{
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}, 1'b1,
      '{1'b1, 1'b0, ORIENT_UNKNOWN, 17'd0, 21'd0, 21'd0}},
    '{'{16'sd0, 16'sd0, 16'sd2048, 16'sd0, 16'sd0, 16'sd0, 1'b0}, 1'b1,
      '{1'b1, 1'b1, ORIENT_UPRIGHT, 17'd0, 21'd2048, 21'd0}},
    '{'{16'sd0, 16'sd1600, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}, 1'b0, NoResult},
    '{'{16'sd1600, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}, 1'b1,
      '{1'b1, 1'b1, ORIENT_NOT_UPRIGHT, 17'd0, 21'd1250, 21'd1250}},
    '{'{-16'sd1300, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}, 1'b0, NoResult},
    '{'{16'sd1229, 16'sd600, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}, 1'b0, NoResult},
    '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b1, ErrorResult},
    '{'{16'sd1229, 16'sd600, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}, 1'b0, NoResult},
    '{'{16'sd1300, 16'sd0, 16'sd0, -16'sd100, 16'sd99, 16'sd0, 1'b0}, 1'b0, NoResult},
    '{'{16'sd0, 16'sd0, 16'sd2048, 16'sd200, 16'sd0, 16'sd0, 1'b0}, 1'b1,
      '{1'b1, 1'b0, ORIENT_UNKNOWN, 17'd200, 21'd2048, 21'd0}},
    '{'{16'sd0, 16'sd0, 16'sd2710, 16'sd0, 16'sd0, 16'sd0, 1'b0}, 1'b1,
      '{1'b1, 1'b0, ORIENT_UNKNOWN, 17'd0, 21'd3585, 21'd0}},
    '{'{16'sd0, 16'sd0, 16'sd2709, 16'sd0, 16'sd0, 16'sd0, 1'b0}, 1'b0, NoResult},
    '{'{16'sd0, 16'sd0, 16'sd2028, 16'sd0, 16'sd0, 16'sd0, 1'b0}, 1'b0, NoResult},
    '{'{16'sd0, 16'sd0, 16'sd2029, 16'sd0, 16'sd0, 16'sd0, 1'b0}, 1'b0, NoResult},
    '{'{16'sd917, 16'sd0, 16'sd2048, 16'sd0, 16'sd0, 16'sd0, 1'b0}, 1'b0, NoResult},
    '{'{16'sd916, 16'sd0, 16'sd2048, 16'sd0, 16'sd0, 16'sd0, 1'b0}, 1'b0, NoResult},
    '{'{16'sd0, 16'sd1296, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}, 1'b0, NoResult},
    '{'{16'sd2244, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}, 1'b0, NoResult},
    '{'{16'sd2243, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}, 1'b0, NoResult},
    '{'{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0}, 1'b1,
      '{1'b1, 1'b0, ORIENT_UNKNOWN, 17'd98304, 21'd1572864, 21'd1048576}},
    '{'{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0}, 1'b1,
      '{1'b1, 1'b0, ORIENT_UNKNOWN, 17'd98301, 21'd1572768, 21'd1048512}},
    '{'{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b1}, 1'b1, ErrorResult},
    '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0}, 1'b1,
      '{1'b1, 1'b0, ORIENT_UNKNOWN, 17'd3, 21'd0, 21'd0}},
    '{'{16'sd0, 16'sd0, -16'sd2048, 16'sd0, 16'sd0, 16'sd0, 1'b0}, 1'b0, NoResult}
  };

  localparam cfg_t DefaultLimits = '{
    rate_still_limit: 17'd200, accel_norm_limit: 15'd3584, upright_tilt_limit: 15'd410,
    tilt_band_low: 15'd820, tilt_band_high: 15'd2458, side_accel_limit: 15'd1229,
    vertical_accel_limit: 16'sd2028
  };
  localparam cfg_t ZeroLimits = '0;
  localparam cfg_t WideLimits = '{
    rate_still_limit: 17'd131071, accel_norm_limit: 15'd32767, upright_tilt_limit: 15'd32767,
    tilt_band_low: 15'd32767, tilt_band_high: 15'd32767, side_accel_limit: 15'd32767,
    vertical_accel_limit: 16'h8000
  };
  localparam cfg_t InvertedBand = '{
    rate_still_limit: 17'd400, accel_norm_limit: 15'd8000, upright_tilt_limit: 15'd100,
    tilt_band_low: 15'd3000, tilt_band_high: 15'd900, side_accel_limit: 15'd200,
    vertical_accel_limit: -16'sd500
  };
  localparam cfg_t EmptyBand = '{
    rate_still_limit: 17'd300, accel_norm_limit: 15'd4000, upright_tilt_limit: 15'd600,
    tilt_band_low: 15'd1500, tilt_band_high: 15'd1500, side_accel_limit: 15'd1000,
    vertical_accel_limit: 16'sd32767
  };

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  isoc_stream_if #(.T(in_t))  sample_if ();
  isoc_stream_if #(.T(out_t)) result_if ();

  imu_stillness_orientation_classifier DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (sample_if),
    .result_o   (result_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  cfg_t limits_m;
  logic still_m;
  out_t pending_results [$];
  out_t predicted;
  logic row_typed;
  out_t row_result;
  int   mismatches = 0;
  int   cycles = 0;
  int   burst_left = 0;
  int   rx_mode = 0;
  int   rx_left = 0;
  logic tx_steady;
  logic pressure_go;
  logic hold_off;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int scaled_square(input int v);
    int m;
    m = magnitude(v);
    return (m * m) / 2048;
  endfunction

  function automatic out_t classify_sample(input in_t s);
    out_t r;
    int   ax;
    int   az;
    int   rsum;
    int   tilt;
    int   total;
    r = '0;
    if (s.read_error) begin
      still_m = 1'b0;
      return r;
    end
    ax = s.accel_x;
    az = s.accel_z;
    rsum = magnitude(s.rate_x) + magnitude(s.rate_y) + magnitude(s.rate_z);
    tilt = scaled_square(ax) + scaled_square(s.accel_y);
    total = tilt + scaled_square(az);
    if (rsum < int'(limits_m.rate_still_limit) && total < int'(limits_m.accel_norm_limit)) begin
      if (tilt < int'(limits_m.upright_tilt_limit) &&
          az > int'(limits_m.vertical_accel_limit)) begin
        r.orientation = ORIENT_UPRIGHT;
        still_m = 1'b1;
      end else if (int'(limits_m.tilt_band_low) < tilt &&
                   tilt < int'(limits_m.tilt_band_high)) begin
        if (magnitude(ax) > int'(limits_m.side_accel_limit)) begin
          r.orientation = ORIENT_NOT_UPRIGHT;
          still_m = 1'b1;
        end
      end else begin
        still_m = 1'b0;
      end
    end else begin
      still_m = 1'b0;
    end
    r.sample_valid = 1'b1;
    r.is_still = still_m;
    r.rate_sum = 17'(rsum);
    r.full_norm = 21'(total);
    r.tilt_norm = 21'(tilt);
    return r;
  endfunction

  function automatic void check_result(input out_t got);
    out_t want;
    logic same;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected result item: still %0b orient %0d rate_sum %0d", got.is_still,
                 got.orientation, got.rate_sum);
      end
      return;
    end
    want = pending_results.pop_front();
    same = got.sample_valid === want.sample_valid && got.is_still === want.is_still &&
           got.orientation === want.orientation && got.rate_sum === want.rate_sum &&
           got.full_norm === want.full_norm && got.tilt_norm === want.tilt_norm;
    if (!same) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch (exp/act): valid %0b/%0b still %0b/%0b orient %0d/%0d",
                 want.sample_valid, got.sample_valid, want.is_still, got.is_still,
                 want.orientation, got.orientation);
        $display("  rate_sum %0d/%0d full_norm %0d/%0d tilt_norm %0d/%0d",
                 want.rate_sum, got.rate_sum, want.full_norm, got.full_norm,
                 want.tilt_norm, got.tilt_norm);
      end
    end
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sample_if.valid && sample_if.ready) begin
        predicted = classify_sample(sample_if.payload);
        pending_results.push_back(row_typed ? row_result : predicted);
      end
      if (result_if.valid && result_if.ready) begin
        check_result(result_if.payload);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(20, 120);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: begin
        result_if.ready <= !hold_off;
      end
      1: begin
        result_if.ready <= !hold_off && ($urandom_range(0, 1) == 1);
      end
      2: begin
        result_if.ready <= !hold_off && (cycles % 4 == 0);
      end
      default: begin
        result_if.ready <= !hold_off && ($urandom_range(0, 99) < 85);
      end
    endcase
  end

  initial begin
    hold_off = 1'b0;
    wait (pressure_go);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  function automatic logic [15:0] around(input int centre, input int span);
    int v;
    v = centre + int'($urandom_range(0, 2 * span)) - span;
    return v[15:0];
  endfunction

  function automatic in_t random_sample();
    in_t s;
    int  pick;
    s = '0;
    pick = $urandom_range(0, 9);
    s.rate_x = around(0, 90);
    s.rate_y = around(0, 90);
    s.rate_z = around(0, 90);
    case (pick)
      0, 1: begin
        s.accel_x = 16'($urandom);
        s.accel_y = 16'($urandom);
        s.accel_z = 16'($urandom);
        s.rate_x = 16'($urandom);
        s.rate_y = 16'($urandom);
        s.rate_z = 16'($urandom);
        s.read_error = (pick == 0);
      end
      2, 3, 4: begin
        s.accel_x = around(0, 700);
        s.accel_y = around(0, 700);
        s.accel_z = around(2048, 600);
      end
      5, 6, 7: begin
        s.accel_x = around(($urandom_range(0, 1) == 1) ? 1500 : -1500, 600);
        s.accel_y = around(0, 900);
        s.accel_z = around(0, 800);
      end
      8: begin
        s.accel_x = around(0, 3000);
        s.accel_y = around(0, 3000);
        s.accel_z = around(0, 3000);
        s.rate_x = around(0, 250);
        s.rate_y = around(0, 250);
        s.rate_z = around(0, 250);
      end
      default: begin
        s.accel_x = around(0, 500);
        s.accel_y = around(0, 500);
        s.accel_z = around(2048, 500);
        s.rate_z = 16'($urandom);
      end
    endcase
    return s;
  endfunction

  task automatic send_sample(input in_t s, input logic typed, input out_t result);
    logic taken;
    int   gap;
    sample_if.valid <= 1'b1;
    sample_if.payload <= s;
    row_typed <= typed;
    row_result <= result;
    do begin
      @(negedge clk_i);
      taken = sample_if.valid && sample_if.ready;
      @(posedge clk_i);
    end while (!taken);
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0 && !tx_steady) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(1, 8);
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    sample_if.valid <= 1'b0;
    while (pending_results.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_sample(random_sample(), 1'b0, NoResult);
    drain();
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_RATE_STILL_LIMIT:     limits_m.rate_still_limit = data;
      CFG_ACCEL_NORM_LIMIT:     limits_m.accel_norm_limit = data[14:0];
      CFG_UPRIGHT_TILT_LIMIT:   limits_m.upright_tilt_limit = data[14:0];
      CFG_TILT_BAND_LOW:        limits_m.tilt_band_low = data[14:0];
      CFG_TILT_BAND_HIGH:       limits_m.tilt_band_high = data[14:0];
      CFG_SIDE_ACCEL_LIMIT:     limits_m.side_accel_limit = data[14:0];
      CFG_VERTICAL_ACCEL_LIMIT: limits_m.vertical_accel_limit = data[15:0];
      default: begin
      end
    endcase
    @(posedge clk_i);
  endtask

  task automatic load_limits(input cfg_t c);
    write_reg(CFG_RATE_STILL_LIMIT, c.rate_still_limit);
    write_reg(CFG_ACCEL_NORM_LIMIT, {2'b00, c.accel_norm_limit});
    write_reg(CFG_UPRIGHT_TILT_LIMIT, {2'b00, c.upright_tilt_limit});
    write_reg(CFG_TILT_BAND_LOW, {2'b00, c.tilt_band_low});
    write_reg(CFG_TILT_BAND_HIGH, {2'b00, c.tilt_band_high});
    write_reg(CFG_SIDE_ACCEL_LIMIT, {2'b00, c.side_accel_limit});
    write_reg(CFG_VERTICAL_ACCEL_LIMIT, {1'b0, c.vertical_accel_limit});
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_RATE_STILL_LIMIT;
    cfg_data_i = '0;
    sample_if.valid = 1'b0;
    sample_if.payload = '0;
    result_if.ready = 1'b0;
    row_typed = 1'b0;
    row_result = NoResult;
    tx_steady = 1'b0;
    pressure_go = 1'b0;
    limits_m = DefaultLimits;
    still_m = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      send_sample(DirectedRows[i].sample, DirectedRows[i].typed, DirectedRows[i].result);
    end
    drain();

    // The receiver holds off while the sender keeps offering, so the block backs up.
    tx_steady = 1'b1;
    pressure_go = 1'b1;
    repeat (60) send_sample(random_sample(), 1'b0, NoResult);
    tx_steady = 1'b0;
    run_random(220);

    load_limits(ZeroLimits);
    run_random(70);
    load_limits(WideLimits);
    write_reg(CfgIdxUnused, CfgDataW'($urandom));
    run_random(70);
    load_limits(InvertedBand);
    run_random(70);
    load_limits(EmptyBand);
    run_random(70);
    for (int i = 0; i <= CfgIdxUnused; i++) begin
      write_reg(CfgIdxW'(i), CfgDataW'($urandom));
    end
    run_random(70);
    load_limits(DefaultLimits);
    run_random(70);

    mismatches += pending_results.size();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/isoc_pkg.sv
design/isoc_stream_if.sv
design/isoc_datapath.sv
design/isoc_classify.sv
design/imu_stillness_orientation_classifier.sv
tb/tb_imu_stillness_orientation_classifier.sv
